/* rtl/clra_pkg.sv */
// Package: shared types, constants and codes for the CPU lend/reclaim allocator.
package clra_pkg;

    localparam int unsigned PROC_COUNT_DEF = 8;
    localparam logic [2:0]  DEFAULT_CPUS_RESET = 3'd4;
    localparam logic [5:0]  COUNT_MAX = 6'd56;
    localparam logic [5:0]  COUNT_RESET = 6'd4;

    typedef enum logic [1:0] {
        REQ_LEND    = 2'd0,
        REQ_ACQUIRE = 2'd1,
        REQ_INIT    = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_LEND_EMPTY = 2'd1,
        ST_ACQ_HOLD   = 2'd2,
        ST_ACQ_SHORT  = 2'd3
    } t_status;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_DONE   = 1'b1;

    localparam logic [1:0] REG_DEFAULT_CPUS = 2'd0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_LEND_RD,
        S_LEND_CHK,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_GIVE_RD,
        S_GIVE_WR,
        S_ACQ_RD,
        S_ACQ_CHK,
        S_RECL_RD,
        S_RECL_CMP,
        S_INIT_WR,
        S_SELF_WR,
        S_DONE_RD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       kind;
        logic [2:0] target_proc;
        logic [5:0] new_count;
        logic [1:0] status;
        logic [5:0] idle_count;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  proc_id;
        logic [31:0] secs_comp;
    } t_request;

    function automatic logic [5:0] sat_inc(input logic [5:0] a);
        return (a >= COUNT_MAX) ? COUNT_MAX : a + 6'd1;
    endfunction

endpackage

/* rtl/clra_stream_if.sv */
// Interface: valid/ready channel carrying one payload.
interface clra_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/cpu_lend_reclaim_allocator_core.sv */
// Top level: CPU lend/reclaim allocator with count and time memories.
//
// channel   | dir | payload
// i_req     | in  | req_type, proc_id, secs_comp
// o_res     | out | kind, target_proc, new_count, status, idle_count, last
// apb       | in  | default_cpus at byte address 0
//
// One request at a time. Memory reads are registered.
// A lend scans the ring once per CPU handed out. After reset a pass over
// every entry clears the memories; no request is taken during it. A stalled
// result holds the sequencer, and no new request is taken until it has left.
module cpu_lend_reclaim_allocator_core
    import clra_pkg::*;
#(
    parameter int unsigned PROC_COUNT = PROC_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    clra_stream_if.sink   i_req,
    clra_stream_if.source o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int unsigned PW = (PROC_COUNT > 1) ? $clog2(PROC_COUNT) : 1;

    logic [5:0]  cnt_mem [PROC_COUNT];
    logic [31:0] time_mem [PROC_COUNT];

    t_state      r_state, n_state;
    logic [2:0]  r_dflt;
    logic [5:0]  r_idle, n_idle;
    t_request    r_req, n_req;
    logic [PW-1:0] r_idx, n_idx;
    logic [PW:0] r_k, n_k;
    logic [5:0]  r_left, n_left;
    logic [5:0]  r_miss, n_miss;
    logic        r_found, n_found;
    logic [PW-1:0] r_best, n_best;
    logic [5:0]  r_bcnt, n_bcnt;
    logic [31:0] r_btime, n_btime;
    logic [1:0]  r_st, n_st;
    t_result     r_out, n_out;
    logic        r_ovalid, n_ovalid;

    logic [63:0] r_pa, r_pb;
    logic        r_ppend;
    logic [PW-1:0] r_pidx;
    logic [5:0]  r_pcnt;
    logic [31:0] r_ptime;

    logic [PW-1:0] rd_addr;
    logic [5:0]  rd_cnt;
    logic [31:0] rd_time;
    logic        cw_en, tw_en;
    logic [PW-1:0] cw_addr, tw_addr;
    logic [5:0]  cw_data;
    logic [31:0] tw_data;

    logic [PW-1:0] pid;
    logic [PW-1:0] ring;
    logic          out_free;
    logic [2:0]    pid3;

    assign pid      = r_req.proc_id[PW-1:0];
    assign pid3     = r_req.proc_id;
    assign out_free = !r_ovalid || o_res.ready;
    assign pready   = 1'b1;
    assign prdata   = (paddr == REG_DEFAULT_CPUS) ? {29'd0, r_dflt} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dflt <= DEFAULT_CPUS_RESET;
        end else if (psel && penable && pwrite && paddr == REG_DEFAULT_CPUS) begin
            r_dflt <= pwdata[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cw_en) begin
            cnt_mem[cw_addr] <= cw_data;
        end
        if (tw_en) begin
            time_mem[tw_addr] <= tw_data;
        end
        rd_cnt  <= cnt_mem[rd_addr];
        rd_time <= time_mem[rd_addr];
    end

    // ring position: ring = (pid + r_k) mod PROC_COUNT
    always_comb begin
        logic [PW:0] s;
        s = {1'b0, pid} + r_k;
        if (s >= (PW+1)'(PROC_COUNT)) begin
            s = s - (PW+1)'(PROC_COUNT);
        end
        ring = s[PW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_idle   <= 6'd0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
            r_ppend  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idle   <= n_idle;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
            r_ppend  <= (r_state == S_SCAN_RD);
        end
        r_req   <= n_req;
        r_k     <= n_k;
        r_left  <= n_left;
        r_miss  <= n_miss;
        r_found <= n_found;
        r_best  <= n_best;
        r_bcnt  <= n_bcnt;
        r_btime <= n_btime;
        r_st    <= n_st;
        r_out   <= n_out;
        r_pidx  <= r_idx;
        r_pa    <= 64'(rd_time) * 64'(r_bcnt);
        r_pb    <= 64'(r_btime) * 64'(rd_cnt);
        r_pcnt  <= rd_cnt;
        r_ptime <= rd_time;
    end

    assign i_req.ready = (r_state == S_IDLE) && out_free;
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_out;

    always_comb begin
        n_state  = r_state;
        n_idle   = r_idle;
        n_req    = r_req;
        n_idx    = r_idx;
        n_k      = r_k;
        n_left   = r_left;
        n_miss   = r_miss;
        n_found  = r_found;
        n_best   = r_best;
        n_bcnt   = r_bcnt;
        n_btime  = r_btime;
        n_st     = r_st;
        n_out    = r_out;
        n_ovalid = r_ovalid && !o_res.ready;
        rd_addr  = r_idx;
        cw_en    = 1'b0;
        tw_en    = 1'b0;
        cw_addr  = r_idx;
        tw_addr  = pid;
        cw_data  = 6'd0;
        tw_data  = r_req.secs_comp;

        case (r_state)
            S_CLEAR: begin
                cw_en   = 1'b1;
                tw_en   = 1'b1;
                tw_addr = r_idx;
                cw_data = COUNT_RESET;
                tw_data = 32'd0;
                n_idx   = r_idx + PW'(1);
                if (r_idx == PW'(PROC_COUNT - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid && out_free) begin
                    n_req = i_req.data;
                    n_st  = ST_OK;
                    n_idx = i_req.data.proc_id[PW-1:0];
                    if (32'(i_req.data.proc_id) >= PROC_COUNT
                            || i_req.data.req_type == REQ_NONE) begin
                        n_out    = '{KIND_DONE, i_req.data.proc_id, 6'd0, ST_OK,
                                     r_idle, 1'b1};
                        n_ovalid = 1'b1;
                    end else begin
                        case (i_req.data.req_type)
                            REQ_LEND:    n_state = S_LEND_RD;
                            REQ_ACQUIRE: n_state = S_ACQ_RD;
                            default: begin
                                n_idx   = '0;
                                n_state = S_INIT_WR;
                            end
                        endcase
                    end
                end
            end
            S_LEND_RD: begin
                tw_en   = 1'b1;
                n_state = S_LEND_CHK;
            end
            S_LEND_CHK: begin
                if (rd_cnt == 6'd0) begin
                    n_st    = ST_LEND_EMPTY;
                    n_state = S_DONE_RD;
                end else begin
                    n_left  = rd_cnt;
                    n_k     = (PW+1)'(1);
                    n_found = 1'b0;
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                rd_addr = ring;
                n_idx   = ring;
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                // wait for the registered cross products
                if (r_ppend) begin
                    n_state = S_SCAN_CMP;
                end
                if (!r_ppend) begin
                    if (r_pcnt != 6'd0 && (!r_found || r_pa > r_pb)) begin
                        n_found = 1'b1;
                        n_best  = r_pidx;
                        n_bcnt  = r_pcnt;
                        n_btime = r_ptime;
                    end
                    if (r_k == (PW+1)'(PROC_COUNT - 1)) begin
                        n_state = S_GIVE_RD;
                    end else begin
                        n_k     = r_k + (PW+1)'(1);
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_GIVE_RD: begin
                if (!r_found) begin
                    n_idle  = ({1'b0, r_idle} + {1'b0, r_left} > {1'b0, COUNT_MAX})
                              ? COUNT_MAX : r_idle + r_left;
                    n_left  = 6'd0;
                    n_state = S_SELF_WR;
                end else if (out_free) begin
                    cw_en    = 1'b1;
                    cw_addr  = r_best;
                    cw_data  = sat_inc(r_bcnt);
                    n_out    = '{KIND_UPDATE, 3'(r_best), sat_inc(r_bcnt), ST_OK,
                                 6'd0, 1'b0};
                    n_ovalid = 1'b1;
                    n_left   = r_left - 6'd1;
                    n_state  = S_GIVE_WR;
                end
            end
            S_GIVE_WR: begin
                if (r_left == 6'd0) begin
                    n_state = S_SELF_WR;
                end else begin
                    n_k     = (PW+1)'(1);
                    n_found = 1'b0;
                    n_state = S_SCAN_RD;
                end
            end
            S_ACQ_RD: begin
                n_state = S_ACQ_CHK;
            end
            S_ACQ_CHK: begin
                if (rd_cnt != 6'd0) begin
                    n_st    = ST_ACQ_HOLD;
                    n_state = S_DONE_RD;
                end else if (r_idle >= 6'(r_dflt)) begin
                    n_idle  = r_idle - 6'(r_dflt);
                    n_miss  = 6'd0;
                    n_state = S_SELF_WR;
                end else begin
                    n_miss  = 6'(r_dflt) - r_idle;
                    n_idle  = 6'd0;
                    n_k     = (PW+1)'(1);
                    n_state = S_RECL_RD;
                end
            end
            S_RECL_RD: begin
                rd_addr = ring;
                n_idx   = ring;
                n_state = S_RECL_CMP;
            end
            S_RECL_CMP: begin
                if (rd_cnt > 6'(r_dflt)) begin
                    if (out_free) begin
                        cw_en   = 1'b1;
                        if (r_miss > rd_cnt - 6'(r_dflt)) begin
                            cw_data = 6'(r_dflt);
                            n_miss  = r_miss - (rd_cnt - 6'(r_dflt));
                        end else begin
                            cw_data = rd_cnt - r_miss;
                            n_miss  = 6'd0;
                        end
                        n_out    = '{KIND_UPDATE, 3'(r_idx), cw_data, ST_OK, 6'd0, 1'b0};
                        n_ovalid = 1'b1;
                        if (n_miss == 6'd0 || r_k == (PW+1)'(PROC_COUNT - 1)) begin
                            n_state = S_SELF_WR;
                        end else begin
                            n_k     = r_k + (PW+1)'(1);
                            n_state = S_RECL_RD;
                        end
                    end
                end else if (r_k == (PW+1)'(PROC_COUNT - 1)) begin
                    n_state = S_SELF_WR;
                end else begin
                    n_k     = r_k + (PW+1)'(1);
                    n_state = S_RECL_RD;
                end
            end
            S_INIT_WR: begin
                if (out_free) begin
                    cw_en    = 1'b1;
                    cw_data  = 6'(r_dflt);
                    n_idle   = 6'd0;
                    n_out    = '{KIND_UPDATE, 3'(r_idx), 6'(r_dflt), ST_OK, 6'd0, 1'b0};
                    n_ovalid = 1'b1;
                    n_idx    = r_idx + PW'(1);
                    if (r_idx == PW'(PROC_COUNT - 1)) begin
                        n_idx   = pid;
                        n_state = S_DONE_RD;
                    end
                end
            end
            S_SELF_WR: begin
                cw_en   = 1'b1;
                cw_addr = pid;
                cw_data = (r_req.req_type == REQ_LEND) ? 6'd0 : 6'(r_dflt);
                if (r_req.req_type == REQ_ACQUIRE && r_miss != 6'd0
                        && r_st == ST_OK && n_idle == 6'd0) begin
                    n_st = ST_ACQ_SHORT;
                end
                n_idx   = pid;
                n_state = S_DONE_RD;
            end
            S_DONE_RD: begin
                rd_addr = pid;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out    = '{KIND_DONE, pid3, rd_cnt, r_st, r_idle, 1'b1};
                    n_ovalid = 1'b1;
                    n_miss   = 6'd0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* rtl/clra_checker.sv */
// Checker: port-level properties of the allocator, bound to the top level.
module clra_checker
    import clra_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    req_valid,
    input logic    req_ready,
    input logic    res_valid,
    input logic    res_ready,
    input t_result res_data
);
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (res_data.kind == res_data.last))
        else $error("done and last disagree");

    a_upd_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && res_data.kind == KIND_UPDATE |->
            res_data.status == ST_OK && res_data.idle_count == 6'd0)
        else $error("update carries status");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> res_data.new_count <= COUNT_MAX && res_data.idle_count <= COUNT_MAX)
        else $error("count above limit");

    a_req_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && req_ready |-> !(res_valid && !res_ready))
        else $error("request taken while result stalled");
endmodule

bind cpu_lend_reclaim_allocator_core clra_checker u_clra_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .req_valid (i_req.valid),
    .req_ready (i_req.ready),
    .res_valid (o_res.valid),
    .res_ready (o_res.ready),
    .res_data  (o_res.data)
);

/* tb/tb.sv */
// Testbench for cpu_lend_reclaim_allocator_core: directed and random requests vs a local model.
module tb;
    import clra_pkg::*;

    localparam int NPROC = 8;
    localparam longint LIMIT = 3_000_000;
    localparam int SETTLE = 64;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    clra_stream_if #(.T(t_request)) req_if ();
    clra_stream_if #(.T(t_result))  res_if ();

    cpu_lend_reclaim_allocator_core #(.PROC_COUNT(NPROC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req(req_if.sink), .o_res(res_if.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    logic [5:0]  cpus_mdl [NPROC];
    logic [31:0] time_mdl [NPROC];
    logic [5:0]  idle_mdl;
    logic [2:0]  dflt_mdl;
    t_result     pending_results[$];
    int          errors = 0;
    int          n_reqs = 0;
    int          n_results = 0;
    longint      cycles = 0;
    int          sink_stall = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("cpu_lend_reclaim_allocator_core regression: fail");
            $finish;
        end
    end

    function automatic logic [5:0] sat_add6(input logic [5:0] a, input logic [6:0] b);
        logic [7:0] s;
        s = a + b;
        return (s > 56) ? 6'd56 : s[5:0];
    endfunction

    function automatic void push_res(input logic k, input logic [2:0] t, input logic [5:0] c,
                                     input logic [1:0] st, input logic [5:0] idle,
                                     input logic lst);
        t_result r;
        r.kind = k; r.target_proc = t; r.new_count = c;
        r.status = st; r.idle_count = idle; r.last = lst;
        pending_results.push_back(r);
    endfunction

    function automatic void allocate(input t_request rq);
        logic [2:0] p;
        logic [1:0] st;
        logic [5:0] left, missing, extra;
        int best, idx;
        p = rq.proc_id;
        st = ST_OK;
        if (rq.req_type == REQ_NONE) begin
            push_res(KIND_DONE, p, 6'd0, ST_OK, idle_mdl, 1'b1);
            return;
        end
        if (rq.req_type == REQ_LEND) begin
            time_mdl[p] = rq.secs_comp;
            if (cpus_mdl[p] == 0) begin
                st = ST_LEND_EMPTY;
            end else begin
                left = cpus_mdl[p];
                while (left > 0) begin
                    best = -1;
                    for (int k = 1; k < NPROC; k++) begin
                        idx = (p + k) % NPROC;
                        if (cpus_mdl[idx] != 0) begin
                            if (best < 0 ||
                                64'(time_mdl[idx]) * cpus_mdl[best] >
                                64'(time_mdl[best]) * cpus_mdl[idx])
                                best = idx;
                        end
                    end
                    if (best < 0) begin
                        idle_mdl = sat_add6(idle_mdl, {1'b0, left});
                        left = 6'd0;
                    end else begin
                        cpus_mdl[best] = sat_add6(cpus_mdl[best], 7'd1);
                        left--;
                        push_res(KIND_UPDATE, 3'(best), cpus_mdl[best], ST_OK, 6'd0, 1'b0);
                    end
                end
                cpus_mdl[p] = 6'd0;
            end
        end else if (rq.req_type == REQ_ACQUIRE) begin
            if (cpus_mdl[p] != 0) begin
                st = ST_ACQ_HOLD;
            end else begin
                missing = 6'(dflt_mdl);
                if (idle_mdl >= 6'(dflt_mdl)) begin
                    idle_mdl = idle_mdl - 6'(dflt_mdl);
                    missing = 6'd0;
                end else begin
                    missing = missing - idle_mdl;
                    idle_mdl = 6'd0;
                    for (int k = 1; k < NPROC && missing != 0; k++) begin
                        idx = (p + k) % NPROC;
                        if (cpus_mdl[idx] > 6'(dflt_mdl)) begin
                            extra = cpus_mdl[idx] - 6'(dflt_mdl);
                            if (missing > extra) begin
                                missing = missing - extra;
                                cpus_mdl[idx] = 6'(dflt_mdl);
                            end else begin
                                cpus_mdl[idx] = cpus_mdl[idx] - missing;
                                missing = 6'd0;
                            end
                            push_res(KIND_UPDATE, 3'(idx), cpus_mdl[idx], ST_OK, 6'd0, 1'b0);
                        end
                    end
                end
                cpus_mdl[p] = 6'(dflt_mdl);
                if (missing != 0) st = ST_ACQ_SHORT;
            end
        end else begin
            idle_mdl = 6'd0;
            for (int i = 0; i < NPROC; i++) begin
                cpus_mdl[i] = 6'(dflt_mdl);
                push_res(KIND_UPDATE, 3'(i), cpus_mdl[i], ST_OK, 6'd0, 1'b0);
            end
        end
        push_res(KIND_DONE, p, cpus_mdl[p], st, idle_mdl, 1'b1);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result sink: random stalls, check on accept
    always @(negedge i_clk) begin
        if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) sink_stall <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_result got, exp_r;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = res_if.data;
            n_results++;
            if (pending_results.size() == 0) begin
                $error("unexpected result %p", got);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (got.kind !== exp_r.kind) begin
                    $error("kind exp %0d got %0d", exp_r.kind, got.kind); errors++;
                end
                if (got.target_proc !== exp_r.target_proc) begin
                    $error("target_proc exp %0d got %0d", exp_r.target_proc, got.target_proc);
                    errors++;
                end
                if (got.new_count !== exp_r.new_count) begin
                    $error("new_count exp %0d got %0d", exp_r.new_count, got.new_count);
                    errors++;
                end
                if (got.status !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
                end
                if (got.idle_count !== exp_r.idle_count) begin
                    $error("idle_count exp %0d got %0d", exp_r.idle_count, got.idle_count);
                    errors++;
                end
                if (got.last !== exp_r.last) begin
                    $error("last exp %0d got %0d", exp_r.last, got.last); errors++;
                end
            end
        end
    end

    // called at a negedge; returns at a negedge with valid still high
    task automatic send_req(input t_req ty, input logic [2:0] p, input logic [31:0] secs);
        t_request rq;
        int gap;
        rq.req_type = ty; rq.proc_id = p; rq.secs_comp = secs;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= rq;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        allocate(rq);
        n_reqs++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_default(input logic [2:0] v);
        drain();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= REG_DEFAULT_CPUS; pwdata <= {29'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        dflt_mdl = v;
        @(negedge i_clk);
        if (prdata !== {29'd0, v}) begin
            $error("prdata exp %0d got %0d", v, prdata); errors++;
        end
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_req(REQ_LEND, 3'd0, 32'hFFFF_FFFF);
        send_req(REQ_LEND, 3'd0, 32'd0);
        send_req(REQ_ACQUIRE, 3'd1, 32'd0);
        send_req(REQ_ACQUIRE, 3'd0, 32'hA5A5_5A5A);
        send_req(REQ_LEND, 3'd7, 32'd1);
        send_req(REQ_LEND, 3'd5, 32'd1000);
        send_req(REQ_NONE, 3'd2, 32'h1234_5678);
        send_req(REQ_INIT, 3'd7, 32'd0);
        for (int i = 0; i < NPROC; i++) send_req(REQ_LEND, 3'(i), 32'(7 * i));
        send_req(REQ_ACQUIRE, 3'd2, 32'd0);
        send_req(REQ_ACQUIRE, 3'd4, 32'd0);
        send_req(REQ_INIT, 3'd0, 32'd0);
        // pause until all results are back
        drain();
        send_req(REQ_LEND, 3'd6, 32'h8000_0000);
        send_req(REQ_ACQUIRE, 3'd6, 32'd0);
    endtask

    task automatic test_config();
        set_default(3'd7);
        send_req(REQ_LEND, 3'd3, 32'd50);
        send_req(REQ_ACQUIRE, 3'd3, 32'd0);
        send_req(REQ_LEND, 3'd1, 32'd9);
        send_req(REQ_ACQUIRE, 3'd1, 32'd0);
        send_req(REQ_INIT, 3'd0, 32'd0);
        set_default(3'd0);
        send_req(REQ_LEND, 3'd2, 32'd5);
        send_req(REQ_ACQUIRE, 3'd2, 32'd0);
        send_req(REQ_INIT, 3'd1, 32'd0);
        send_req(REQ_LEND, 3'd4, 32'd5);
        set_default(3'd1);
        send_req(REQ_INIT, 3'd2, 32'd0);
    endtask

    task automatic test_random();
        t_req ty;
        int r;
        for (int n = 0; n < 270; n++) begin
            if (n % 75 == 74) set_default(3'($urandom_range(0, 7)));
            r = $urandom_range(0, 99);
            if (r < 45) ty = REQ_LEND;
            else if (r < 85) ty = REQ_ACQUIRE;
            else if (r < 95) ty = REQ_INIT;
            else ty = REQ_NONE;
            send_req(ty, 3'($urandom_range(0, NPROC - 1)),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        res_if.ready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        for (int i = 0; i < NPROC; i++) begin
            cpus_mdl[i] = COUNT_RESET;
            time_mdl[i] = '0;
        end
        idle_mdl = '0;
        dflt_mdl = DEFAULT_CPUS_RESET;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_config();
        test_random();
        drain();
        $display("Covered %0d requests (lend, acquire, init, unknown) and %0d results,",
                 n_reqs, n_results);
        $display("with default CPU counts from 0 to 7 and random stalls on both sides.");
        if (errors == 0) begin
            $display("cpu_lend_reclaim_allocator_core regression: pass");
        end else begin
            $display("cpu_lend_reclaim_allocator_core regression: fail");
        end
        $finish;
    end
endmodule

/* sim.f */
rtl/clra_pkg.sv
rtl/clra_stream_if.sv
rtl/cpu_lend_reclaim_allocator_core.sv
rtl/clra_checker.sv
tb/tb.sv
